@@ sv/swerve_drive_inverse_kinematics_top_macros.svh @@
// assertion macros used by the checker file
`ifndef SWERVE_DRIVE_INVERSE_KINEMATICS_TOP_MACROS_SVH
`define SWERVE_DRIVE_INVERSE_KINEMATICS_TOP_MACROS_SVH

// implication checked on every rising edge outside reset
`define SDIK_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
        else $error("sdik check failed");

// condition that must never be seen outside reset
`define SDIK_ASSERT_NEVER(lbl, clk, rst_n, bad) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(bad)) \
        else $error("sdik check failed");

`endif

@@ sv/sdik_pkg.sv @@
// ----------------------------------------------------------------------------
// sdik_pkg
// widths, latencies, register indexes and arctangent table of the swerve
// drive inverse kinematics pipeline
// ----------------------------------------------------------------------------
`default_nettype none

package sdik_pkg;

    // cordic depth and table size
    localparam int CORDIC_STAGES = 16;
    localparam int ATAN_ENTRIES  = 24;

    // datapath widths
    localparam int VEL_W   = 16;
    localparam int CFG_W   = 16;
    localparam int PRODT_W = 33;
    localparam int ROT_W   = 17;
    localparam int VEC_W   = 18;
    localparam int CORD_W  = 29;
    localparam int PHASE_W = 32;
    localparam int OUT_W   = 16;
    localparam int SQ_W    = 36;
    localparam int RAD_W   = 44;
    localparam int ROOT_W  = 22;
    localparam int REM_W   = 26;
    localparam int PRODS_W = 38;

    // latencies
    localparam int WHEEL_LAT = 26;
    localparam int FRONT_LAT = 3;
    localparam int LATENCY   = FRONT_LAT + WHEEL_LAT;
    localparam int ANG_DELAY = WHEEL_LAT - CORDIC_STAGES - 2;

    // configuration register indexes
    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_TRACK = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_GAIN = 8'd1;
    localparam logic [CFG_W-1:0] HALF_TRACK_RST = 16'd10486;
    localparam logic [CFG_W-1:0] SPEED_GAIN_RST = 16'd2560;

    // arctangent of 2^-i, 2^32 counts per turn
    localparam logic [PHASE_W-1:0] ATAN_TURNS [ATAN_ENTRIES] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    // one wheel velocity vector, Q.12
    typedef struct packed {
        logic signed [VEC_W-1:0] x;
        logic signed [VEC_W-1:0] y;
    } t_wheel_vec;

endpackage

`default_nettype wire

@@ sv/sdik_cordic.sv @@
// ----------------------------------------------------------------------------
// sdik_cordic
// pipelined cordic vectoring unit giving the steering angle of one wheel,
// aligned to the latency of the speed path
// ----------------------------------------------------------------------------
`default_nettype none

module sdik_cordic (
    input  wire logic                      i_clk,
    input  wire sdik_pkg::t_wheel_vec      i_vec,
    output logic [sdik_pkg::OUT_W-1:0]     o_angle
);

    localparam int N = sdik_pkg::CORDIC_STAGES;
    localparam int W = sdik_pkg::CORD_W;

    logic signed [W-1:0]                 r_x    [0:N];
    logic signed [W-1:0]                 r_y    [0:N];
    logic [sdik_pkg::PHASE_W-1:0]        r_z    [0:N];
    logic                                r_zero [0:N];
    logic [sdik_pkg::OUT_W-1:0]          r_angle [0:sdik_pkg::ANG_DELAY];

    logic signed [W-1:0]          n_sx;
    logic signed [W-1:0]          n_sy;
    logic [sdik_pkg::PHASE_W-1:0] n_round;

    // scale by 2^8 and fold the left half plane onto the right
    assign n_sx = {{(W - sdik_pkg::VEC_W - 8){i_vec.x[sdik_pkg::VEC_W-1]}}, i_vec.x, 8'b0};
    assign n_sy = {{(W - sdik_pkg::VEC_W - 8){i_vec.y[sdik_pkg::VEC_W-1]}}, i_vec.y, 8'b0};

    always_ff @(posedge i_clk) begin
        r_zero[0] <= (i_vec.x == '0) && (i_vec.y == '0);
        if (n_sx < 0) begin
            r_x[0] <= -n_sx;
            r_y[0] <= -n_sy;
            r_z[0] <= 32'h8000_0000;
        end else begin
            r_x[0] <= n_sx;
            r_y[0] <= n_sy;
            r_z[0] <= '0;
        end
    end

    // micro-rotation stages
    for (genvar i = 0; i < N; i++) begin : g_stage
        always_ff @(posedge i_clk) begin
            r_zero[i+1] <= r_zero[i];
            if (r_y[i] > 0) begin
                r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                r_z[i+1] <= r_z[i] + sdik_pkg::ATAN_TURNS[i];
            end else begin
                r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                r_z[i+1] <= r_z[i] - sdik_pkg::ATAN_TURNS[i];
            end
        end
    end

    // round the phase to 16 bits, zero vector gives angle 0
    assign n_round = r_z[N] + 32'h0000_8000;

    always_ff @(posedge i_clk) begin
        r_angle[0] <= r_zero[N] ? '0 : n_round[sdik_pkg::PHASE_W-1:sdik_pkg::PHASE_W-16];
    end

    // delay line matching the speed path
    for (genvar j = 0; j < sdik_pkg::ANG_DELAY; j++) begin : g_delay
        always_ff @(posedge i_clk) begin
            r_angle[j+1] <= r_angle[j];
        end
    end

    assign o_angle = r_angle[sdik_pkg::ANG_DELAY];

endmodule

`default_nettype wire

@@ sv/sdik_speed.sv @@
// ----------------------------------------------------------------------------
// sdik_speed
// drive speed of one wheel: squares, pipelined bit-pair square root,
// gain multiply with rounding and saturation
// ----------------------------------------------------------------------------
`default_nettype none

module sdik_speed (
    input  wire logic                         i_clk,
    input  wire sdik_pkg::t_wheel_vec         i_vec,
    input  wire logic [sdik_pkg::CFG_W-1:0]   i_speed_gain,
    output logic [sdik_pkg::OUT_W-1:0]        o_speed
);

    localparam int RW = sdik_pkg::ROOT_W;
    localparam int MW = sdik_pkg::REM_W;
    localparam int VW = sdik_pkg::RAD_W;

    logic signed [2*sdik_pkg::VEC_W-1:0] n_xx;
    logic signed [2*sdik_pkg::VEC_W-1:0] n_yy;
    logic [sdik_pkg::SQ_W-1:0]           r_xx;
    logic [sdik_pkg::SQ_W-1:0]           r_yy;
    logic [sdik_pkg::SQ_W:0]             n_sum;

    logic [VW-1:0] r_rad  [0:RW];
    logic [MW-1:0] r_rem  [0:RW];
    logic [RW-1:0] r_root [0:RW];

    logic [sdik_pkg::PRODS_W-1:0] r_prod;
    logic [sdik_pkg::PRODS_W:0]   n_rnd;
    logic [sdik_pkg::OUT_W-1:0]   r_speed;

    // squares of the components
    assign n_xx = i_vec.x * i_vec.x;
    assign n_yy = i_vec.y * i_vec.y;

    always_ff @(posedge i_clk) begin
        r_xx <= n_xx[sdik_pkg::SQ_W-1:0];
        r_yy <= n_yy[sdik_pkg::SQ_W-1:0];
    end

    // sum of squares scaled by 2^8
    assign n_sum = {1'b0, r_xx} + {1'b0, r_yy};

    always_ff @(posedge i_clk) begin
        r_rad[0]  <= {n_sum[sdik_pkg::SQ_W-1:0], 8'b0};
        r_rem[0]  <= '0;
        r_root[0] <= '0;
    end

    // one root bit per stage
    for (genvar k = 0; k < RW; k++) begin : g_sqrt
        logic [MW-1:0] n_rem_sh;
        logic [MW-1:0] n_trial;
        assign n_rem_sh = {r_rem[k][MW-3:0], r_rad[k][VW-1:VW-2]};
        assign n_trial  = {{(MW - RW - 2){1'b0}}, r_root[k], 2'b01};
        always_ff @(posedge i_clk) begin
            r_rad[k+1] <= {r_rad[k][VW-3:0], 2'b00};
            if (n_rem_sh >= n_trial) begin
                r_rem[k+1]  <= n_rem_sh - n_trial;
                r_root[k+1] <= {r_root[k][RW-2:0], 1'b1};
            end else begin
                r_rem[k+1]  <= n_rem_sh;
                r_root[k+1] <= {r_root[k][RW-2:0], 1'b0};
            end
        end
    end

    // gain multiply
    always_ff @(posedge i_clk) begin
        r_prod <= i_speed_gain * r_root[RW];
    end

    // round and saturate
    assign n_rnd = {1'b0, r_prod} + 39'd32768;

    always_ff @(posedge i_clk) begin
        if (n_rnd[sdik_pkg::PRODS_W:32] != '0) begin
            r_speed <= '1;
        end else begin
            r_speed <= n_rnd[31:16];
        end
    end

    assign o_speed = r_speed;

endmodule

`default_nettype wire

@@ sv/swerve_drive_inverse_kinematics_top.sv @@
// o_valid is raised for each accepted start when it leaves the valid shift register
// throughput: one command per cycle, busy is never raised
// the latency is set by the 22-stage square root pipeline of the speed path
// results are shown for one cycle only, the receiver cannot stall
// reset clears the valid pipeline and loads the default half-track and gain
// ----------------------------------------------------------------------------
// swerve_drive_inverse_kinematics_top
// four-wheel swerve drive inverse kinematics, fully pipelined
// ----------------------------------------------------------------------------
`default_nettype none

module swerve_drive_inverse_kinematics_top (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic signed [sdik_pkg::VEL_W-1:0]   i_lin_vel_x,
    input  wire logic signed [sdik_pkg::VEL_W-1:0]   i_lin_vel_y,
    input  wire logic signed [sdik_pkg::VEL_W-1:0]   i_yaw_rate,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [sdik_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [sdik_pkg::CFG_W-1:0]          i_cfg_data,
    output logic                                     o_valid,
    output logic [sdik_pkg::OUT_W-1:0]               o_angle_front_left,
    output logic [sdik_pkg::OUT_W-1:0]               o_angle_front_right,
    output logic [sdik_pkg::OUT_W-1:0]               o_angle_rear_left,
    output logic [sdik_pkg::OUT_W-1:0]               o_angle_rear_right,
    output logic [sdik_pkg::OUT_W-1:0]               o_speed_front_left,
    output logic [sdik_pkg::OUT_W-1:0]               o_speed_front_right,
    output logic [sdik_pkg::OUT_W-1:0]               o_speed_rear_left,
    output logic [sdik_pkg::OUT_W-1:0]               o_speed_rear_right
);

    logic [sdik_pkg::CFG_W-1:0] r_half_track;
    logic [sdik_pkg::CFG_W-1:0] r_speed_gain;
    logic [sdik_pkg::LATENCY-1:0] r_valid;

    logic signed [sdik_pkg::VEL_W-1:0]   r_vx1, r_vy1, r_yaw1;
    logic signed [sdik_pkg::VEL_W-1:0]   r_vx2, r_vy2;
    logic signed [sdik_pkg::PRODT_W-1:0] r_prod;
    logic signed [sdik_pkg::PRODT_W:0]   n_rsum;
    logic signed [sdik_pkg::ROT_W-1:0]   n_rot;
    logic signed [sdik_pkg::VEC_W-1:0]   n_vx, n_vy, n_rt;
    sdik_pkg::t_wheel_vec                r_wheel [4];
    logic [sdik_pkg::OUT_W-1:0]          w_angle [4];
    logic [sdik_pkg::OUT_W-1:0]          w_speed [4];

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_track <= sdik_pkg::HALF_TRACK_RST;
            r_speed_gain <= sdik_pkg::SPEED_GAIN_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                sdik_pkg::CFG_HALF_TRACK: r_half_track <= i_cfg_data;
                sdik_pkg::CFG_SPEED_GAIN: r_speed_gain <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // valid bits travelling with each transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= {r_valid[sdik_pkg::LATENCY-2:0], start};
        end
    end

    assign o_valid = r_valid[sdik_pkg::LATENCY-1];

    // command capture and rotation product
    always_ff @(posedge i_clk) begin
        r_vx1  <= i_lin_vel_x;
        r_vy1  <= i_lin_vel_y;
        r_yaw1 <= i_yaw_rate;
        r_vx2  <= r_vx1;
        r_vy2  <= r_vy1;
        r_prod <= r_yaw1 * $signed({1'b0, r_half_track});
    end

    // rounded rotation term and wheel vectors
    assign n_rsum = {r_prod[sdik_pkg::PRODT_W-1], r_prod} + 34'sd32768;
    assign n_rot  = n_rsum[32:16];
    assign n_vx   = {{2{r_vx2[sdik_pkg::VEL_W-1]}}, r_vx2};
    assign n_vy   = {{2{r_vy2[sdik_pkg::VEL_W-1]}}, r_vy2};
    assign n_rt   = {n_rot[sdik_pkg::ROT_W-1], n_rot};

    always_ff @(posedge i_clk) begin
        r_wheel[0] <= '{x: n_vx - n_rt, y: n_vy + n_rt};
        r_wheel[1] <= '{x: n_vx + n_rt, y: n_vy + n_rt};
        r_wheel[2] <= '{x: n_vx - n_rt, y: n_vy - n_rt};
        r_wheel[3] <= '{x: n_vx + n_rt, y: n_vy - n_rt};
    end

    // per-wheel angle and speed units
    for (genvar w = 0; w < 4; w++) begin : g_wheel
        sdik_cordic u_cordic (
            .i_clk   (i_clk),
            .i_vec   (r_wheel[w]),
            .o_angle (w_angle[w])
        );
        sdik_speed u_speed (
            .i_clk        (i_clk),
            .i_vec        (r_wheel[w]),
            .i_speed_gain (r_speed_gain),
            .o_speed      (w_speed[w])
        );
    end

    assign o_angle_front_left  = w_angle[0];
    assign o_angle_front_right = w_angle[1];
    assign o_angle_rear_left   = w_angle[2];
    assign o_angle_rear_right  = w_angle[3];
    assign o_speed_front_left  = w_speed[0];
    assign o_speed_front_right = w_speed[1];
    assign o_speed_rear_left   = w_speed[2];
    assign o_speed_rear_right  = w_speed[3];

endmodule

`default_nettype wire

@@ sv/sdik_checker.sv @@
// ----------------------------------------------------------------------------
// sdik_checker
// port-level checks of the swerve drive pipeline, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "swerve_drive_inverse_kinematics_top_macros.svh"

module sdik_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic o_cfg_ready,
    input wire logic o_valid
);

    // every accepted transaction yields a strobe after the fixed latency
    `SDIK_ASSERT_IMPLY(a_start_to_valid, i_clk, i_rst_n, start && !busy, ##(sdik_pkg::LATENCY) o_valid)

    // no strobe without a transaction accepted at that latency
    `SDIK_ASSERT_IMPLY(a_valid_has_start, i_clk, i_rst_n, o_valid, $past(start, sdik_pkg::LATENCY))

    // pipeline never refuses a command
    `SDIK_ASSERT_NEVER(a_never_busy, i_clk, i_rst_n, busy)

    // configuration port always open
    `SDIK_ASSERT_NEVER(a_cfg_ready, i_clk, i_rst_n, !o_cfg_ready)

endmodule

bind swerve_drive_inverse_kinematics_top sdik_checker u_sdik_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_cfg_ready (o_cfg_ready),
    .o_valid     (o_valid)
);

`default_nettype wire
